>>> rtl/core/cdso_pkg.sv
// cdso_pkg: shared constants, types and calendar helpers for the
// calendar date seconds offset block. No dependencies.
package cdso_pkg;

    localparam int unsigned QUOT_W = 16;  // quotient bits of the shared divider
    localparam int unsigned DVD_W  = 33;  // dividend bits of the shared divider
    localparam int unsigned DVS_W  = 17;  // divisor bits of the shared divider

    // Reciprocal divide: x = dividend >> PRE, quotient = (x * RECIP) >> SHIFT.
    // RECIP is rounded up; the rounding error times the largest x stays below
    // 2^SHIFT, so the quotient is exact over the whole dividend range.
    localparam int unsigned RCP_X_W = 26;
    localparam int unsigned RCP_M_W = 27;
    localparam int unsigned PROD_W  = RCP_X_W + RCP_M_W;
    localparam int unsigned DAY_PRE    = 7;   // 86400 = 128 * 675
    localparam int unsigned DAY_SHIFT  = 36;
    localparam logic [RCP_M_W-1:0] DAY_RECIP  = 27'd101806633;  // ceil(2^36 / 675)
    localparam int unsigned YEAR_PRE   = 4;   // 400 = 16 * 25
    localparam int unsigned YEAR_SHIFT = 18;
    localparam logic [RCP_M_W-1:0] YEAR_RECIP = 27'd10486;      // ceil(2^18 / 25)

    localparam logic [DVS_W-1:0] SEC_PER_DAY = 17'd86400;
    localparam logic [DVS_W-1:0] YEAR_CYCLE  = 17'd400;
    // 82 * 400: lifts any 16-bit signed year to a positive value, same mod 400
    localparam logic [16:0]      YEAR_BIAS   = 17'd32800;
    // 24856 days in seconds: lifts any second total to a positive value
    localparam logic [33:0]      SEC_BIAS    = 34'd2147558400;
    localparam logic [16:0]      DAY_BIAS    = 17'd24856;

    localparam logic [8:0]  YMOD_LAST   = 9'd399;
    localparam logic [8:0]  YMOD_AT_MIN = 9'd32;   // -32768 mod 400
    localparam logic [8:0]  YMOD_AT_MAX = 9'd367;  //  32767 mod 400
    localparam logic signed [15:0] YEAR_MAX = 16'sh7FFF;
    localparam logic signed [15:0] YEAR_MIN = 16'sh8000;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DVS_W-1:0]  rem;
    } t_div_stat;

    // Leap rule on the year taken mod 400 (floor), valid for negative years
    function automatic logic is_leap(input logic [8:0] ymod);
        logic by4;
        by4 = (ymod[1:0] == 2'd0);
        return (by4 && ymod != 9'd100 && ymod != 9'd200 && ymod != 9'd300)
            || (ymod == 9'd0);
    endfunction

    // Month is already in 1..12
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == MONTH_FEB && leap) begin
            return 5'd29;
        end
        if (idx > 4'd11) begin
            return 5'd31;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

>>> rtl/core/cdso_div.sv
// cdso_div: shared divider by 400 or by 86400, reciprocal multiply for the
// quotient and a back-multiply for the remainder.
// Depends on cdso_pkg.
module cdso_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_by_day,
    input  logic [cdso_pkg::DVD_W-1:0]   i_dividend,
    output cdso_pkg::t_div_stat          o_stat
);
    import cdso_pkg::*;

    logic [DVD_W-1:0]        r_dvd;
    logic                    r_by_day;
    logic [RCP_X_W-1:0]      r_x;
    logic [PROD_W-1:0]       r_prod;
    logic [QUOT_W-1:0]       r_quot;
    logic [DVS_W-1:0]        r_rem;
    logic [2:0]              r_phase;  // product, quotient, remainder
    logic                    r_done;

    logic [RCP_X_W-1:0]      x_sel;
    logic [RCP_M_W-1:0]      recip;
    logic [DVS_W-1:0]        divisor;
    logic [PROD_W-1:0]       quot_full;
    logic [QUOT_W+DVS_W-1:0] back_mul;
    logic [DVD_W-1:0]        rem_full;

    // drop the power-of-two factor of the divisor up front
    assign x_sel = i_by_day ? i_dividend[DVD_W-1:DAY_PRE]
                            : i_dividend[RCP_X_W+YEAR_PRE-1:YEAR_PRE];

    assign recip     = r_by_day ? DAY_RECIP : YEAR_RECIP;
    assign divisor   = r_by_day ? SEC_PER_DAY : YEAR_CYCLE;
    assign quot_full = r_by_day ? (r_prod >> DAY_SHIFT) : (r_prod >> YEAR_SHIFT);
    assign back_mul  = {{DVS_W{1'b0}}, r_quot} * {{QUOT_W{1'b0}}, divisor};
    assign rem_full  = r_dvd - back_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= {r_phase[1:0], i_start};
            r_done  <= r_phase[2];
            if (i_start) begin
                r_dvd    <= i_dividend;
                r_by_day <= i_by_day;
                r_x      <= x_sel;
            end
            if (r_phase[0]) begin
                r_prod <= PROD_W'(r_x) * PROD_W'(recip);
            end
            if (r_phase[1]) begin
                r_quot <= quot_full[QUOT_W-1:0];
            end
            if (r_phase[2]) begin
                r_rem <= rem_full[DVS_W-1:0];
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;
    assign o_stat.rem  = r_rem;

endmodule

>>> rtl/core/calendar_date_seconds_offset_top.sv
// calendar_date_seconds_offset_top: adds a signed second offset to a Gregorian
// date and second of day. Depends on cdso_pkg and cdso_div.
//
//   channel  valid     stall     payload
//   input    i_valid   o_stall   i_in_year i_in_month i_in_day i_in_second
//                                i_offset_seconds
//   output   o_valid   i_stall   o_out_year o_out_month o_out_day o_out_second
//                                o_year_overflow
//
// A beat whose date does not move goes, after accept, through two passes of the
// shared reciprocal divider (year mod 400, then the second total by 86400), one
// step in the day stepper and the output load, once the output register is free.
// The stepper takes one more step per month boundary crossed and one more when
// the move ends inside a month; the next beat can be taken in the cycle after the load.
// Reset is synchronous, active low, and clears control state only.
// o_stall is high from accept until the result moves into the output register;
// a result waiting on i_stall does not block the next input beat.
module calendar_date_seconds_offset_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_in_year,
    input  logic [3:0]         i_in_month,
    input  logic [4:0]         i_in_day,
    input  logic [16:0]        i_in_second,
    input  logic signed [31:0] i_offset_seconds,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_year,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic [16:0]        o_out_second,
    output logic               o_year_overflow
);
    import cdso_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YDIV,
        ST_TDIV,
        ST_STEP,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic [16:0]        r_sec;
    logic signed [31:0] r_off;
    logic [8:0]         r_ymod;
    logic [15:0]        r_n;      // days left to move
    logic               r_back;   // moving backward
    logic               r_ovf;

    logic               r_ovalid;
    logic signed [15:0] r_oyear;
    logic [3:0]         r_omonth;
    logic [4:0]         r_oday;
    logic [16:0]        r_osec;
    logic               r_oovf;

    // shared divider
    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic               div_by_day;
    t_div_stat          div_stat;

    logic               in_take;
    logic               out_free;
    logic [3:0]         in_month_sat;
    logic [16:0]        year_lift;
    logic [33:0]        total_lift;
    logic [16:0]        qs;
    logic [4:0]         dim_cur;
    logic [4:0]         gap;
    logic [4:0]         day_clamp;

    // next-year values for a carry up or a borrow down
    logic signed [15:0] year_up;
    logic [8:0]         ymod_up;
    logic               ovf_up;
    logic signed [15:0] year_dn;
    logic [8:0]         ymod_dn;
    logic               ovf_dn;
    logic [3:0]         month_dn;
    logic [8:0]         ymod_dn_sel;
    logic [4:0]         dim_dn;

    assign in_take  = (r_state == ST_IDLE) && i_valid;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        in_month_sat = i_in_month;
        if (i_in_month < MONTH_FIRST) begin
            in_month_sat = MONTH_FIRST;
        end else if (i_in_month > MONTH_LAST) begin
            in_month_sat = MONTH_LAST;
        end
    end

    // year + 32800 always lands in 0..2^17-1, so plain wrap-around add is exact
    assign year_lift  = {i_in_year[15], i_in_year} + YEAR_BIAS;
    assign total_lift = {17'd0, r_sec} + {{2{r_off[31]}}, r_off} + SEC_BIAS;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {16'd0, year_lift};
        div_by_day   = 1'b0;
        if (in_take) begin
            div_start = 1'b1;
        end else if (r_state == ST_YDIV && div_stat.done) begin
            div_start    = 1'b1;
            div_dividend = total_lift[DVD_W-1:0];
            div_by_day   = 1'b1;
        end
    end

    cdso_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_by_day   (div_by_day),
        .i_dividend (div_dividend),
        .o_stat     (div_stat)
    );

    // signed whole-day count, undo the bias
    assign qs = {1'b0, div_stat.quot} - DAY_BIAS;

    assign dim_cur   = days_in(r_month, is_leap(r_ymod));
    assign gap       = dim_cur - r_day;
    assign day_clamp = (r_day > dim_cur) ? dim_cur : r_day;

    always_comb begin
        if (r_year == YEAR_MAX) begin
            year_up = YEAR_MIN;
            ymod_up = YMOD_AT_MIN;
            ovf_up  = 1'b1;
        end else begin
            year_up = r_year + 16'sd1;
            ymod_up = (r_ymod == YMOD_LAST) ? 9'd0 : r_ymod + 9'd1;
            ovf_up  = 1'b0;
        end
        if (r_year == YEAR_MIN) begin
            year_dn = YEAR_MAX;
            ymod_dn = YMOD_AT_MAX;
            ovf_dn  = 1'b1;
        end else begin
            year_dn = r_year - 16'sd1;
            ymod_dn = (r_ymod == 9'd0) ? YMOD_LAST : r_ymod - 9'd1;
            ovf_dn  = 1'b0;
        end
        month_dn    = (r_month == MONTH_FIRST) ? MONTH_LAST : r_month - 4'd1;
        ymod_dn_sel = (r_month == MONTH_FIRST) ? ymod_dn : r_ymod;
        dim_dn      = days_in(month_dn, is_leap(ymod_dn_sel));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // in ST_DONE the output load below decides the valid flag
            if (r_ovalid && !i_stall && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_year  <= i_in_year;
                        r_month <= in_month_sat;
                        r_day   <= (i_in_day == 5'd0) ? 5'd1 : i_in_day;
                        r_sec   <= i_in_second;
                        r_off   <= i_offset_seconds;
                        r_ovf   <= 1'b0;
                        r_state <= ST_YDIV;
                    end
                end
                ST_YDIV: begin
                    if (div_stat.done) begin
                        r_ymod  <= div_stat.rem[8:0];
                        r_state <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    // year mod 400 is known now: clamp the day to its month
                    if (div_stat.done) begin
                        r_sec   <= div_stat.rem;
                        r_day   <= day_clamp;
                        r_back  <= qs[16];
                        r_n     <= qs[16] ? 16'(-qs) : qs[15:0];
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (r_n == 16'd0) begin
                        r_state <= ST_DONE;
                    end else if (!r_back) begin
                        if (r_n <= {11'd0, gap}) begin
                            r_day <= r_day + r_n[4:0];
                            r_n   <= 16'd0;
                        end else begin
                            // advance to the first of the next month
                            r_n   <= r_n - {11'd0, gap} - 16'd1;
                            r_day <= 5'd1;
                            if (r_month == MONTH_LAST) begin
                                r_month <= MONTH_FIRST;
                                r_year  <= year_up;
                                r_ymod  <= ymod_up;
                                r_ovf   <= r_ovf | ovf_up;
                            end else begin
                                r_month <= r_month + 4'd1;
                            end
                        end
                    end else begin
                        if (r_n < {11'd0, r_day}) begin
                            r_day <= r_day - r_n[4:0];
                            r_n   <= 16'd0;
                        end else begin
                            // drop to the last day of the previous month
                            r_n     <= r_n - {11'd0, r_day};
                            r_month <= month_dn;
                            r_day   <= dim_dn;
                            if (r_month == MONTH_FIRST) begin
                                r_year <= year_dn;
                                r_ymod <= ymod_dn;
                                r_ovf  <= r_ovf | ovf_dn;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_oyear  <= r_year;
                        r_omonth <= r_month;
                        r_oday   <= r_day;
                        r_osec   <= r_sec;
                        r_oovf   <= r_ovf;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_out_year      = r_oyear;
    assign o_out_month     = r_omonth;
    assign o_out_day       = r_oday;
    assign o_out_second    = r_osec;
    assign o_year_overflow = r_oovf;

endmodule
